// ===== sv/lpm_pkg.sv =====
`default_nettype none
package lpm_pkg;

  localparam int ROUTES_DEF = 32;
  localparam int ADDR_W     = 32;
  localparam int PLEN_W     = 6;
  localparam int TTL_W      = 8;
  localparam int CKS_W      = 16;
  localparam int ACT_W      = 3;
  localparam int CMD_W      = 2;

  localparam logic [PLEN_W-1:0] MAX_PLEN   = PLEN_W'(32);
  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;
  localparam logic [CKS_W:0]    TTL_CKS_INC = (CKS_W+1)'(16'h0100);

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd2;

  localparam logic [ACT_W-1:0] ACT_CLEARED  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADDED    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FULL     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOCAL    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FORWARD  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DROP_TTL = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NO_ROUTE = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_length;
    logic [ADDR_W-1:0] route_next_hop;
    logic [TTL_W-1:0]  time_to_live;
    logic [CKS_W-1:0]  header_checksum;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] chosen_next_hop;
    logic [TTL_W-1:0]  new_ttl;
    logic [CKS_W-1:0]  new_checksum;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] hop;
  } route_t;

  // netmask for a prefix length of 0..32
  function automatic logic [ADDR_W-1:0] len_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_PLEN - len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ipv4_forward_lpm_engine.sv =====
`default_nettype none
// Clear, add, reserved commands and forwards decided without lookup (TTL zero,
// local/broadcast, empty table): result the cycle after the transfer, busy stays low.
// Lookup: one stored route per cycle through the single table read port and one
// matcher; result after scanning N routes and S_FIN, S_RESP; busy high meanwhile.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
// Reset: table empty, local_address 0; route entries themselves are not cleared.
module ipv4_forward_lpm_engine #(
  parameter int ROUTES = lpm_pkg::ROUTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire lpm_pkg::in_item_t in_item,
  output logic                out_valid,
  output lpm_pkg::out_item_t  out_item,
  input  wire                 cfg_we,
  input  wire [31:0]          cfg_wdata
);
  import lpm_pkg::*;

  localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int CW = $clog2(ROUTES + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(ROUTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_RESP} state_t;

  state_t            state_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     cnt_r;
  logic [ADDR_W-1:0] local_r;
  in_item_t          item_r;
  route_t            rd_entry_r;
  logic              cmp_vld_r;
  logic              found_r;
  logic [PLEN_W-1:0] best_len_r;
  logic [ADDR_W-1:0] best_hop_r;
  out_item_t         out_r;
  logic              out_valid_r;

  route_t mem [ROUTES];

  logic       accept;
  logic       add_ok;
  logic       hit;
  logic       last_idx;
  logic [CKS_W:0]   cks_sum;
  logic [CKS_W-1:0] cks_adj;
  out_item_t  quick;
  logic       need_scan;
  route_t     wr_entry;

  assign accept   = start && (state_r == S_IDLE);
  assign add_ok   = (in_item.command == CMD_ADD) && (cnt_r != CNT_FULL);
  assign busy     = (state_r != S_IDLE);
  assign hit      = cmp_vld_r &&
                    (((rd_entry_r.prefix ^ item_r.address) & len_mask(rd_entry_r.plen)) == '0) &&
                    (!found_r || (rd_entry_r.plen > best_len_r));
  assign last_idx = ((CW'(idx_r) + CW'(1)) == cnt_r);

  // TTL decrement: +0x0100 with end-around carry
  assign cks_sum = {1'b0, item_r.header_checksum} + TTL_CKS_INC;
  assign cks_adj = cks_sum[CKS_W-1:0] + CKS_W'(cks_sum[CKS_W]);

  assign wr_entry.prefix = in_item.address;
  assign wr_entry.plen   = (in_item.prefix_length > MAX_PLEN) ? MAX_PLEN : in_item.prefix_length;
  assign wr_entry.hop    = in_item.route_next_hop;

  // decisions that need no table lookup
  always_comb begin
    quick.action          = ACT_NO_ROUTE;
    quick.chosen_next_hop = '0;
    quick.new_ttl         = in_item.time_to_live;
    quick.new_checksum    = in_item.header_checksum;
    need_scan             = 1'b0;
    case (in_item.command)
      CMD_CLEAR: quick.action = ACT_CLEARED;
      CMD_ADD:   quick.action = add_ok ? ACT_ADDED : ACT_FULL;
      CMD_FORWARD: begin
        if (in_item.time_to_live == '0) begin
          quick.action = ACT_DROP_TTL;
        end else if (in_item.address == local_r || in_item.address == BCAST_ADDR) begin
          quick.action = ACT_LOCAL;
        end else if (cnt_r != '0) begin
          need_scan = 1'b1;
        end
      end
      default: quick.action = ACT_NO_ROUTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && add_ok) begin
      mem[cnt_r[IW-1:0]] <= wr_entry;
    end
    rd_entry_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      local_r     <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_r <= cfg_wdata;
      end
      out_valid_r <= (state_r == S_RESP) || (accept && !need_scan);
      cmp_vld_r   <= (state_r == S_SCAN);
      if (hit) begin
        found_r    <= 1'b1;
        best_len_r <= rd_entry_r.plen;
        best_hop_r <= rd_entry_r.hop;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_item;
            idx_r   <= '0;
            found_r <= 1'b0;
            if (in_item.command == CMD_CLEAR) begin
              cnt_r <= '0;
            end else if (add_ok) begin
              cnt_r <= cnt_r + CW'(1);
            end
            if (need_scan) begin
              state_r <= S_SCAN;
            end else begin
              out_r <= quick;
            end
          end
        end
        S_SCAN: begin
          if (last_idx) begin
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_FIN: state_r <= S_RESP;
        S_RESP: begin
          state_r <= S_IDLE;
          if (found_r && best_hop_r != '0) begin
            out_r.action          <= ACT_FORWARD;
            out_r.chosen_next_hop <= best_hop_r;
            out_r.new_ttl         <= item_r.time_to_live - TTL_W'(1);
            out_r.new_checksum    <= cks_adj;
          end else begin
            out_r.action          <= ACT_NO_ROUTE;
            out_r.chosen_next_hop <= '0;
            out_r.new_ttl         <= item_r.time_to_live;
            out_r.new_checksum    <= item_r.header_checksum;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== test/ipv4_forward_lpm_engine_test.sv =====
`timescale 1ns / 1ps

import lpm_pkg::*;

class lpm_predictor;
  logic [ADDR_W-1:0] local_addr;
  route_t            routes[ROUTES_DEF];
  int unsigned       route_count;
  out_item_t         expected_results[$];
  int unsigned       mismatches;

  function new();
    local_addr  = '0;
    route_count = 0;
    mismatches  = 0;
  endfunction

  function logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    return (len == 0) ? '0 : ~({ADDR_W{1'b1}} >> len);
  endfunction

  // updates the route table and returns the decision for one command
  function out_item_t decide(input in_item_t cmd);
    out_item_t         res;
    logic              found;
    logic [PLEN_W-1:0] best_len;
    logic [ADDR_W-1:0] best_hop;
    logic [CKS_W:0]    sum;
    res.action          = ACT_NO_ROUTE;
    res.chosen_next_hop = '0;
    res.new_ttl         = cmd.time_to_live;
    res.new_checksum    = cmd.header_checksum;
    case (cmd.command)
      CMD_CLEAR: begin
        route_count = 0;
        res.action = ACT_CLEARED;
      end
      CMD_ADD: begin
        if (route_count >= ROUTES_DEF) begin
          res.action = ACT_FULL;
        end else begin
          routes[route_count].prefix = cmd.address;
          routes[route_count].plen   = (cmd.prefix_length > MAX_PLEN) ? MAX_PLEN
                                                                      : cmd.prefix_length;
          routes[route_count].hop    = cmd.route_next_hop;
          route_count++;
          res.action = ACT_ADDED;
        end
      end
      CMD_FORWARD: begin
        if (cmd.time_to_live == 0) begin
          res.action = ACT_DROP_TTL;
        end else if (cmd.address == local_addr || cmd.address == BCAST_ADDR) begin
          res.action = ACT_LOCAL;
        end else begin
          found    = 1'b0;
          best_len = '0;
          best_hop = '0;
          // strict greater-than keeps the oldest among equal lengths
          for (int i = 0; i < route_count; i++) begin
            if (((routes[i].prefix ^ cmd.address) & prefix_mask(routes[i].plen)) == 0 &&
                (!found || routes[i].plen > best_len)) begin
              found    = 1'b1;
              best_len = routes[i].plen;
              best_hop = routes[i].hop;
            end
          end
          if (found && best_hop != 0) begin
            sum = {1'b0, cmd.header_checksum} + 17'h00100;
            res.action          = ACT_FORWARD;
            res.chosen_next_hop = best_hop;
            res.new_ttl         = cmd.time_to_live - 8'd1;
            res.new_checksum    = sum[CKS_W-1:0] + {{(CKS_W-1){1'b0}}, sum[CKS_W]};
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function void accept_command(input in_item_t cmd);
    expected_results.push_back(decide(cmd));
  endfunction

  function void compare_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  function void check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("action", 32'(want.action), 32'(got.action));
    compare_field("chosen_next_hop", want.chosen_next_hop, got.chosen_next_hop);
    compare_field("new_ttl", 32'(want.new_ttl), 32'(got.new_ttl));
    compare_field("new_checksum", 32'(want.new_checksum), 32'(got.new_checksum));
  endfunction
endclass

module ipv4_forward_lpm_engine_test;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 800;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  in_item_t    in_item   = '0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;

  lpm_predictor      book = new();
  logic [ADDR_W-1:0] nets[4];

  ipv4_forward_lpm_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      book.check_result(out_item);
    end
  end

  function automatic in_item_t pack_item(input logic [CMD_W-1:0] cmd,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [PLEN_W-1:0] plen,
                                         input logic [ADDR_W-1:0] hop,
                                         input logic [TTL_W-1:0] ttl,
                                         input logic [CKS_W-1:0] cks);
    in_item_t it;
    it.command         = cmd;
    it.address         = addr;
    it.prefix_length   = plen;
    it.route_next_hop  = hop;
    it.time_to_live    = ttl;
    it.header_checksum = cks;
    return it;
  endfunction

  function automatic in_item_t noise_item(input logic [CMD_W-1:0] cmd);
    return pack_item(cmd, $urandom, PLEN_W'($urandom_range(0, 63)), $urandom,
                     TTL_W'($urandom_range(0, 255)), CKS_W'($urandom_range(0, 65535)));
  endfunction

  // routes cluster around a few networks so prefixes nest and overlap
  function automatic in_item_t make_route();
    int unsigned       pick;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] hop;
    pick = $urandom_range(0, 99);
    if (pick < 5)       plen = '0;
    else if (pick < 12) plen = PLEN_W'($urandom_range(33, 63));
    else                plen = PLEN_W'($urandom_range(1, 32));
    pick = $urandom_range(0, 99);
    if (pick < 10)      hop = '0;
    else if (pick < 13) hop = '1;
    else                hop = $urandom;
    return pack_item(CMD_ADD, nets[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 31)),
                     plen, hop, TTL_W'($urandom_range(0, 255)),
                     CKS_W'($urandom_range(0, 65535)));
  endfunction

  function automatic in_item_t make_packet();
    int unsigned       pick;
    int unsigned       idx;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
    logic [CKS_W-1:0]  cks;
    pick = $urandom_range(0, 99);
    if (pick < 60 && book.route_count != 0) begin
      idx  = $urandom_range(0, book.route_count - 1);
      mask = book.prefix_mask(book.routes[idx].plen);
      dest = (book.routes[idx].prefix & mask) | ($urandom & ~mask);
    end else if (pick < 70) begin
      dest = book.local_addr;
    end else if (pick < 75) begin
      dest = BCAST_ADDR;
    end else if (pick < 85) begin
      dest = nets[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(1, 31));
    end else begin
      dest = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8)       ttl = '0;
    else if (pick < 16) ttl = 8'd1;
    else if (pick < 20) ttl = '1;
    else                ttl = TTL_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 10) cks = CKS_W'($urandom_range(16'hfe00, 16'hffff));
    else                            cks = CKS_W'($urandom_range(0, 65535));
    return pack_item(CMD_FORWARD, dest, PLEN_W'($urandom_range(0, 63)), $urandom, ttl, cks);
  endfunction

  function automatic in_item_t random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return make_route();
    if (pick < 18) return noise_item(CMD_CLEAR);
    if (pick < 20) return noise_item(CMD_RESERVED);
    return make_packet();
  endfunction

  // start stays high after the transfer; the caller sends again or lowers it
  task automatic send_item(input in_item_t item);
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.accept_command(item);
  endtask

  task automatic write_local(input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (book.expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.local_addr = value;
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    logic        fill;
    in_item_t    it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_local(32'hc0a8_0001);
    send_item(pack_item(CMD_FORWARD, 32'h0808_0808, 6'd0, 32'h0, 8'd64, 16'h1234));
    send_item(pack_item(CMD_FORWARD, 32'h0a05_0505, 6'd0, 32'h0, 8'd0, 16'h4321));
    send_item(pack_item(CMD_FORWARD, 32'hffff_ffff, 6'd0, 32'h0, 8'd5, 16'h0000));
    send_item(pack_item(CMD_FORWARD, 32'hc0a8_0001, 6'd0, 32'h0, 8'd5, 16'hffff));
    send_item(pack_item(CMD_ADD, 32'h0a00_0000, 6'd8, 32'h0a00_00fe, 8'd0, 16'h0));
    send_item(pack_item(CMD_ADD, 32'h0a01_0000, 6'd16, 32'h0, 8'd0, 16'h0));
    send_item(pack_item(CMD_ADD, 32'h0a02_0000, 6'd16, 32'hffff_ffff, 8'd0, 16'h0));
    send_item(pack_item(CMD_ADD, 32'hc000_0001, 6'd63, 32'h1111_1111, 8'hff, 16'hffff));
    // same prefix again: the older route must win
    send_item(pack_item(CMD_ADD, 32'h0a00_0000, 6'd8, 32'h3333_3333, 8'd0, 16'h0));
    send_item(pack_item(CMD_FORWARD, 32'h0a05_0505, 6'd0, 32'h0, 8'd1, 16'hfeff));
    send_item(pack_item(CMD_FORWARD, 32'h0a01_0203, 6'd0, 32'h0, 8'd64, 16'h5555));
    // checksum end-around carry
    send_item(pack_item(CMD_FORWARD, 32'h0a02_0304, 6'd0, 32'h0, 8'd255, 16'hffff));
    send_item(pack_item(CMD_FORWARD, 32'hc000_0001, 6'd0, 32'h0, 8'd10, 16'h0000));
    send_item(pack_item(CMD_FORWARD, 32'hc000_0000, 6'd0, 32'h0, 8'd10, 16'h0000));
    send_item(pack_item(CMD_ADD, 32'h0102_0304, 6'd0, 32'h7f00_0001, 8'd0, 16'h0));
    send_item(pack_item(CMD_FORWARD, 32'hc000_0000, 6'd0, 32'h0, 8'd10, 16'h0000));
    send_item(pack_item(CMD_FORWARD, 32'h0a01_0203, 6'd0, 32'h0, 8'd64, 16'h5555));
    send_item(noise_item(CMD_RESERVED));
    send_item(pack_item(CMD_FORWARD, 32'hffff_ffff, 6'd0, 32'h0, 8'd0, 16'h0101));
    send_item(pack_item(CMD_CLEAR, 32'h0, 6'd0, 32'h0, 8'd0, 16'h0));
    send_item(pack_item(CMD_FORWARD, 32'h0a05_0505, 6'd0, 32'h0, 8'd1, 16'hfeff));
    send_item(pack_item(CMD_ADD, 32'hffff_fffe, 6'd32, 32'h0000_0001, 8'd0, 16'h0));
    send_item(pack_item(CMD_FORWARD, 32'hffff_fffe, 6'd0, 32'h0, 8'd2, 16'h0000));

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       write_local('0);
        1:       write_local('1);
        default: write_local($urandom);
      endcase
      for (int k = 0; k < 4; k++) nets[k] = $urandom;
      span = $urandom_range(40, 100);
      // the first phase always runs the table past full
      fill = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (!fill && $urandom_range(0, 1) == 0) begin
        send_item(noise_item(CMD_CLEAR));
        sent++;
      end
      for (int j = 0; j < span && sent < RANDOM_ITEMS; j++) begin
        if (!(sent >= 250 && sent < 400) && $urandom_range(0, 99) < 38) begin
          start <= 1'b0;
          @(posedge clk);
          while ($urandom_range(0, 99) < 38) @(posedge clk);
        end
        it = (fill && j < 36) ? make_route() : random_item();
        send_item(it);
        sent++;
      end
      phase++;
    end

    start <= 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
